>>> sv/mi3_pkg.sv
// Shared widths and types for the 3x3 matrix inverse.
package mi3_pkg;
   localparam int WORD_W     = 32;
   localparam int FRAC_BITS  = 16;
   localparam int PROD_W     = 2 * WORD_W;
   localparam int COF_W      = 2 * WORD_W + 1;
   localparam int DET_W      = 3 * WORD_W + 3;
   localparam int NUM_W      = COF_W + 2 * FRAC_BITS;
   localparam int QUO_W      = WORD_W + 1;
   localparam int REM_W      = DET_W + 1;
   localparam int FIFO_DEPTH = 16;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int N_ELEM     = 9;

   typedef logic signed [WORD_W-1:0] word_type;

   // cofactors and determinant of one matrix, exact
   typedef struct packed {
      logic [N_ELEM-1:0][COF_W-1:0] cof;
      logic [DET_W-1:0]             det;
   } job_type;
endpackage

>>> sv/mi3_front.sv
// Front end: products, cofactors and exact determinant, fixed six-stage pipeline.
module mi3_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  mi3_pkg::word_type in_m [mi3_pkg::N_ELEM],
   output logic              out_valid,
   output mi3_pkg::job_type  out_job
);
   import mi3_pkg::*;

   localparam int IDX_A [N_ELEM] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
   localparam int IDX_B [N_ELEM] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
   localparam int IDX_C [N_ELEM] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
   localparam int IDX_D [N_ELEM] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

   logic [5:0] vld_ff;

   word_type m1_ff [N_ELEM];
   logic signed [PROD_W-1:0] pa_ff [N_ELEM], pb_ff [N_ELEM];
   logic signed [PROD_W-1:0] pa_in [N_ELEM], pb_in [N_ELEM];
   word_type row2_ff [3], row3_ff [3];
   logic signed [COF_W-1:0] cof3_ff [N_ELEM], cof4_ff [N_ELEM], cof5_ff [N_ELEM];
   logic signed [COF_W-1:0] cof3_in [N_ELEM];
   logic signed [COF_W-1:0] plo_ff [3], phi_ff [3], plo_in [3], phi_in [3];
   logic signed [DET_W-1:0] term_ff [3], term_in [3];
   logic signed [DET_W-1:0] det_ff, det_in;
   logic [N_ELEM-1:0][COF_W-1:0] cof6_ff;

   always_comb begin
      for (int k = 0; k < N_ELEM; k++) begin
         pa_in[k] = PROD_W'(m1_ff[IDX_A[k]]) * PROD_W'(m1_ff[IDX_B[k]]);
         pb_in[k] = PROD_W'(m1_ff[IDX_C[k]]) * PROD_W'(m1_ff[IDX_D[k]]);
         cof3_in[k] = COF_W'(pa_ff[k]) - COF_W'(pb_ff[k]);
      end
      // det terms m0*c0, m1*c3, m2*c6 as two 32x33 partial products each
      for (int t = 0; t < 3; t++) begin
         plo_in[t] = COF_W'(row3_ff[t])
                   * $signed({{(COF_W-WORD_W){1'b0}}, cof3_ff[3*t][WORD_W-1:0]});
         phi_in[t] = COF_W'(row3_ff[t])
                   * COF_W'($signed(cof3_ff[3*t][COF_W-1:WORD_W]));
         term_in[t] = (DET_W'(phi_ff[t]) <<< WORD_W) + DET_W'(plo_ff[t]);
      end
      det_in = term_ff[0] + term_ff[1] + term_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[4:0], in_valid};
      end
      m1_ff   <= in_m;
      pa_ff   <= pa_in;
      pb_ff   <= pb_in;
      for (int t = 0; t < 3; t++) begin
         row2_ff[t] <= m1_ff[t];
      end
      row3_ff <= row2_ff;
      cof3_ff <= cof3_in;
      cof4_ff <= cof3_ff;
      cof5_ff <= cof4_ff;
      plo_ff  <= plo_in;
      phi_ff  <= phi_in;
      term_ff <= term_in;
      det_ff  <= det_in;
      for (int k = 0; k < N_ELEM; k++) begin
         cof6_ff[k] <= cof5_ff[k];
      end
   end

   assign out_valid   = vld_ff[5];
   assign out_job.cof = cof6_ff;
   assign out_job.det = det_ff;
endmodule

>>> sv/mi3_queue.sv
// Job queue between the front end and the divider back end.
module mi3_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  mi3_pkg::job_type push_job,
   input  logic             pop,
   output logic             out_valid,
   output mi3_pkg::job_type out_job
);
   import mi3_pkg::*;

   job_type              mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ff, rd_ff;
   logic [FIFO_AW:0]     cnt_ff, cnt_in;

   assign out_valid = cnt_ff != '0;
   assign out_job   = mem_ff[rd_ff];
   assign cnt_in    = cnt_ff + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
      end
      if (push) begin
         mem_ff[wr_ff] <= push_job;
      end
   end
endmodule

>>> sv/mi3_back.sv
// Back end: magnitudes, restoring divider pipeline, saturation and result register.
module mi3_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  mi3_pkg::job_type  in_job,
   output logic              in_ready,
   output logic              out_valid,
   input  logic              out_stall,
   output mi3_pkg::word_type out_r [mi3_pkg::N_ELEM],
   output mi3_pkg::word_type out_det,
   output logic              out_singular,
   output logic              out_overflow
);
   import mi3_pkg::*;

   typedef struct packed {
      logic [N_ELEM-1:0][REM_W-1:0] rem;
      logic [N_ELEM-1:0][QUO_W-1:0] low;
      logic [N_ELEM-1:0][QUO_W-1:0] quo;
      logic [N_ELEM-1:0]            neg;
      logic [N_ELEM-1:0]            big;
      logic [DET_W-1:0]             dmag;
      logic                         zero;
      logic [WORD_W-1:0]            det_val;
      logic                         det_ov;
   } div_type;

   localparam logic [DET_W-1:0] DHALF = DET_W'(1) << (WORD_W - 1);
   localparam logic [QUO_W-1:0] QHALF = QUO_W'(1) << (WORD_W - 1);
   localparam logic [WORD_W-1:0] WMAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam logic [WORD_W-1:0] WMIN = {1'b1, {(WORD_W-1){1'b0}}};

   logic en;
   logic out_vld_ff;
   assign en        = !out_vld_ff || !out_stall;
   assign in_ready  = en;
   assign out_valid = out_vld_ff;

   // stage A: magnitudes and signs
   logic                a_vld_ff;
   logic [COF_W-1:0]    a_cmag_ff [N_ELEM];
   logic [N_ELEM-1:0]   a_cneg_ff;
   logic [DET_W-1:0]    a_dmag_ff;
   logic                a_dneg_ff, a_zero_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff <= in_valid;
      end
      if (en) begin
         for (int k = 0; k < N_ELEM; k++) begin
            a_cneg_ff[k] <= in_job.cof[k][COF_W-1];
            a_cmag_ff[k] <= in_job.cof[k][COF_W-1] ? -in_job.cof[k] : in_job.cof[k];
         end
         a_dneg_ff <= in_job.det[DET_W-1];
         a_dmag_ff <= in_job.det[DET_W-1] ? -in_job.det : in_job.det;
         a_zero_ff <= in_job.det == '0;
      end
   end

   // stage B builds divider stage 0; stages 1..QUO_W produce one quotient bit each
   div_type           stage_ff [0:QUO_W];
   div_type           stage_in [0:QUO_W];
   logic [QUO_W:0]    svld_ff;

   always_comb begin
      logic [NUM_W-1:0] num;
      logic [DET_W-1:0] tdet;
      stage_in[0] = '0;
      for (int k = 0; k < N_ELEM; k++) begin
         num = {a_cmag_ff[k], {(2*FRAC_BITS){1'b0}}};
         stage_in[0].rem[k] = REM_W'(num >> QUO_W);
         stage_in[0].low[k] = num[QUO_W-1:0];
         stage_in[0].big[k] = REM_W'(num >> QUO_W) >= REM_W'(a_dmag_ff);
         stage_in[0].neg[k] = a_cneg_ff[k] ^ a_dneg_ff;
      end
      stage_in[0].dmag = a_dmag_ff;
      stage_in[0].zero = a_zero_ff;
      tdet = a_dmag_ff >> (2 * FRAC_BITS);
      if (a_dneg_ff) begin
         stage_in[0].det_ov  = tdet > DHALF;
         stage_in[0].det_val = (tdet > DHALF) ? WMIN : -WORD_W'(tdet);
      end else begin
         stage_in[0].det_ov  = tdet > DHALF - 1'b1;
         stage_in[0].det_val = (tdet > DHALF - 1'b1) ? WMAX : WORD_W'(tdet);
      end
   end

   for (genvar j = 0; j < QUO_W; j++) begin : g_div
      always_comb begin
         logic [REM_W-1:0] r2;
         logic             qb;
         stage_in[j+1] = stage_ff[j];
         for (int k = 0; k < N_ELEM; k++) begin
            r2 = {stage_ff[j].rem[k][REM_W-2:0], stage_ff[j].low[k][QUO_W-1]};
            qb = r2 >= REM_W'(stage_ff[j].dmag);
            stage_in[j+1].rem[k] = qb ? r2 - REM_W'(stage_ff[j].dmag) : r2;
            stage_in[j+1].low[k] = {stage_ff[j].low[k][QUO_W-2:0], 1'b0};
            stage_in[j+1].quo[k] = {stage_ff[j].quo[k][QUO_W-2:0], qb};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         svld_ff <= '0;
      end else if (en) begin
         svld_ff <= {svld_ff[QUO_W-1:0], a_vld_ff};
      end
      if (en) begin
         for (int j = 0; j <= QUO_W; j++) begin
            stage_ff[j] <= stage_in[j];
         end
      end
   end

   // saturation and result register
   word_type r_in [N_ELEM];
   logic     ov_in;
   div_type  fin;
   assign fin = stage_ff[QUO_W];

   always_comb begin
      ov_in = fin.det_ov;
      for (int k = 0; k < N_ELEM; k++) begin
         if (fin.neg[k]) begin
            if (fin.big[k] || fin.quo[k] > QHALF) begin
               r_in[k] = WMIN;
               ov_in   = 1'b1;
            end else begin
               r_in[k] = -WORD_W'(fin.quo[k]);
            end
         end else begin
            if (fin.big[k] || fin.quo[k] > QHALF - 1'b1) begin
               r_in[k] = WMAX;
               ov_in   = 1'b1;
            end else begin
               r_in[k] = WORD_W'(fin.quo[k]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= svld_ff[QUO_W];
      end
      if (en) begin
         for (int k = 0; k < N_ELEM; k++) begin
            out_r[k] <= fin.zero ? '0 : r_in[k];
         end
         out_det      <= fin.zero ? '0 : fin.det_val;
         out_singular <= fin.zero;
         out_overflow <= fin.zero ? 1'b0 : ov_in;
      end
   end
endmodule

>>> sv/matrix3x3_inverse.sv
// Top level of the 3x3 matrix inverse (adjugate over determinant, Q16.16).
//
// Usage: the req_ channel carries one matrix per transfer (req_m00..req_m22,
// signed Q16.16); the rsp_ channel returns one transfer per matrix with the
// inverse rsp_r00..rsp_r22, rsp_determinant, rsp_singular and rsp_overflow.
// A transfer happens on a rising edge with valid high and stall low.
// Throughput: one matrix per cycle while req_stall and rsp_stall stay low.
// Front end: six-stage multiplier pipeline (cofactors, exact determinant).
// A 16-entry job queue sits between front and back; req_stall rises only
// when all 16 queue credits are in use, so the front never has to halt.
// Back end: magnitudes, then a 33-stage restoring divider (one quotient bit
// per stage for all nine elements), then saturation into the response
// register. The whole back end holds while rsp_valid is high and rsp_stall
// is high; the queue absorbs the items already in the front end.
// A zero determinant gives all-zero elements with rsp_singular set.
// Reset (synchronous, active high) empties the pipelines and the queue.
module matrix3x3_inverse (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mi3_pkg::word_type req_m00,
   input  mi3_pkg::word_type req_m01,
   input  mi3_pkg::word_type req_m02,
   input  mi3_pkg::word_type req_m10,
   input  mi3_pkg::word_type req_m11,
   input  mi3_pkg::word_type req_m12,
   input  mi3_pkg::word_type req_m20,
   input  mi3_pkg::word_type req_m21,
   input  mi3_pkg::word_type req_m22,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mi3_pkg::word_type rsp_r00,
   output mi3_pkg::word_type rsp_r01,
   output mi3_pkg::word_type rsp_r02,
   output mi3_pkg::word_type rsp_r10,
   output mi3_pkg::word_type rsp_r11,
   output mi3_pkg::word_type rsp_r12,
   output mi3_pkg::word_type rsp_r20,
   output mi3_pkg::word_type rsp_r21,
   output mi3_pkg::word_type rsp_r22,
   output mi3_pkg::word_type rsp_determinant,
   output logic              rsp_singular,
   output logic              rsp_overflow
);
   import mi3_pkg::*;

   word_type m [N_ELEM];
   word_type r [N_ELEM];
   logic     accept, front_valid, q_valid, back_ready, pop;
   job_type  front_job, q_job;
   logic [FIFO_AW:0] credit_ff, credit_in;

   assign m = '{req_m00, req_m01, req_m02, req_m10, req_m11, req_m12,
                req_m20, req_m21, req_m22};

   // credits: matrices accepted but not yet popped from the queue
   assign req_stall = credit_ff == (FIFO_AW+1)'(FIFO_DEPTH);
   assign accept    = req_valid && !req_stall;
   assign pop       = q_valid && back_ready;
   assign credit_in = credit_ff + (FIFO_AW+1)'(accept) - (FIFO_AW+1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
      end else begin
         credit_ff <= credit_in;
      end
   end

   mi3_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_m      (m),
      .out_valid (front_valid),
      .out_job   (front_job)
   );

   mi3_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_job  (front_job),
      .pop       (pop),
      .out_valid (q_valid),
      .out_job   (q_job)
   );

   mi3_back u_back (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (q_valid),
      .in_job       (q_job),
      .in_ready     (back_ready),
      .out_valid    (rsp_valid),
      .out_stall    (rsp_stall),
      .out_r        (r),
      .out_det      (rsp_determinant),
      .out_singular (rsp_singular),
      .out_overflow (rsp_overflow)
   );

   assign rsp_r00 = r[0];
   assign rsp_r01 = r[1];
   assign rsp_r02 = r[2];
   assign rsp_r10 = r[3];
   assign rsp_r11 = r[4];
   assign rsp_r12 = r[5];
   assign rsp_r20 = r[6];
   assign rsp_r21 = r[7];
   assign rsp_r22 = r[8];
endmodule
